// ===== src/tpcm_pkg.sv =====
// tpcm_pkg: types, constants and helper functions for the time-of-flight
// pixel colorize and mask block; no dependencies
`default_nettype none

package tpcm_pkg;

  localparam int unsigned IMAGE_WIDTH  = 320;
  localparam int unsigned IMAGE_HEIGHT = 240;

  localparam logic [15:0] CODE_LOW_AMP = 16'd64001;
  localparam logic [15:0] CODE_ADC_OVF = 16'd64002;
  localparam logic [15:0] CODE_SAT     = 16'd64003;
  localparam logic [15:0] CODE_INTERF  = 16'd64007;
  localparam logic [15:0] CODE_EDGE    = 16'd64008;

  localparam logic [15:0] COLOR_TOP = 16'd12500;
  localparam logic [15:0] SEG_LEN   = 16'd2500;

  // floor(255*t/2500) == (t*RAMP_K) >> RAMP_SHIFT for t in 0..2500
  localparam int unsigned RAMP_SHIFT = 21;
  localparam logic [17:0] RAMP_K     = 18'd213910;

  typedef enum logic [0:0] {
    CFG_CUT_MARGIN = 1'b0,
    CFG_MOD_MODE   = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  function automatic logic [7:0] ramp(input logic [11:0] t);
    logic [29:0] prod;
    prod = 30'(t) * 30'(RAMP_K);
    return prod[RAMP_SHIFT+7:RAMP_SHIFT];
  endfunction

  function automatic logic [15:0] range_limit(input logic [1:0] mode);
    logic [15:0] lim;
    case (mode)
      2'd0:    lim = 16'd6500;
      2'd1:    lim = 16'd12500;
      2'd2:    lim = 16'd25000;
      default: lim = 16'd50000;
    endcase
    return lim;
  endfunction

endpackage

`default_nettype wire

// ===== src/tpcm_if.sv =====
// tpcm_pix_if and tpcm_pt_if: valid/ready channels for input pixels and
// output points; no dependencies
`default_nettype none

interface tpcm_pix_if;
  logic        valid;
  logic        ready;
  logic [15:0] distance_code;
  logic [15:0] amplitude;
  logic [8:0]  column;
  logic [7:0]  row;
  logic        has_amplitude;

  modport source (output valid, distance_code, amplitude, column, row, has_amplitude,
                  input ready);
  modport sink   (input valid, distance_code, amplitude, column, row, has_amplitude,
                  output ready);
endinterface

interface tpcm_pt_if;
  logic              valid;
  logic              ready;
  logic [7:0]        red;
  logic [7:0]        green;
  logic [7:0]        blue;
  logic              point_valid;
  logic [15:0]       point_depth_mm;
  logic signed [8:0] point_lateral;
  logic signed [7:0] point_vertical;
  logic [15:0]       intensity;

  modport source (output valid, red, green, blue, point_valid, point_depth_mm,
                  point_lateral, point_vertical, intensity,
                  input ready);
  modport sink   (input valid, red, green, blue, point_valid, point_depth_mm,
                  point_lateral, point_vertical, intensity,
                  output ready);
endinterface

`default_nettype wire

// ===== src/tpcm_colorize.sv =====
// tpcm_colorize: maps a cleaned distance to a display colour (fixed codes
// and five-segment rainbow); depends on tpcm_pkg
`default_nettype none

module tpcm_colorize import tpcm_pkg::*; (
  input  wire logic [15:0] dist_i,
  output rgb_t             rgb_o
);

  logic [15:0] diff;
  logic [7:0]  ramp_v;

  always_comb begin
    if (dist_i > 16'(4 * SEG_LEN)) begin
      diff = dist_i - 16'(4 * SEG_LEN);
    end else if (dist_i > 16'(3 * SEG_LEN)) begin
      diff = 16'(4 * SEG_LEN) - dist_i;
    end else if (dist_i > 16'(2 * SEG_LEN)) begin
      diff = dist_i - 16'(2 * SEG_LEN);
    end else if (dist_i > SEG_LEN) begin
      diff = 16'(2 * SEG_LEN) - dist_i;
    end else begin
      diff = dist_i;
    end
  end

  assign ramp_v = ramp(diff[11:0]);

  always_comb begin
    rgb_o = '0;
    if (dist_i == CODE_ADC_OVF) begin
      rgb_o = '{red: 8'd169, green: 8'd14, blue: 8'd255};
    end else if (dist_i == CODE_SAT) begin
      rgb_o = '{red: 8'd255, green: 8'd0, blue: 8'd128};
    end else if (dist_i == 16'd0) begin
      rgb_o = '0;
    end else if (dist_i > COLOR_TOP) begin
      rgb_o = '{red: 8'd255, green: 8'd0, blue: 8'd255};
    end else if (dist_i > 16'(4 * SEG_LEN)) begin
      rgb_o = '{red: ramp_v, green: 8'd0, blue: 8'd255};
    end else if (dist_i > 16'(3 * SEG_LEN)) begin
      rgb_o = '{red: 8'd0, green: ramp_v, blue: 8'd255};
    end else if (dist_i > 16'(2 * SEG_LEN)) begin
      rgb_o = '{red: 8'd0, green: 8'd255, blue: ramp_v};
    end else if (dist_i > SEG_LEN) begin
      rgb_o = '{red: ramp_v, green: 8'd255, blue: 8'd0};
    end else begin
      rgb_o = '{red: 8'd255, green: ramp_v, blue: 8'd0};
    end
  end

endmodule

`default_nettype wire

// ===== src/tof_pixel_colorize_and_mask.sv =====
// path from input transfer to result: input register, then result register
// throughput: one pixel per cycle unless the output stalls, pixels are independent
// a waiting result does not stall the input register while it is empty
// reset clears the stage valids; cut_margin resets to 0, modulation_mode to 1
// top level; depends on tpcm_pkg, tpcm_pix_if, tpcm_pt_if, tpcm_colorize
`default_nettype none

module tof_pixel_colorize_and_mask import tpcm_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [0:0] cfg_idx_i,
  input  wire logic [7:0] cfg_data_i,
  tpcm_pix_if.sink        pix_i,
  tpcm_pt_if.source       pt_o
);

  localparam logic signed [11:0] WM_BASE = 12'(IMAGE_WIDTH - 1);
  localparam logic signed [11:0] HM_BASE = 12'(IMAGE_HEIGHT - 1);
  localparam logic [8:0]         LAT_OFS = 9'(IMAGE_WIDTH - 1 - IMAGE_WIDTH / 2);
  localparam logic [7:0]         VER_OFS = 8'(IMAGE_HEIGHT / 2);

  // configuration
  logic [7:0] cut_q;
  logic [1:0] mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cut_q  <= 8'd0;
      mode_q <= 2'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CUT_MARGIN: cut_q  <= cfg_data_i;
        CFG_MOD_MODE:   mode_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic        s1_v_q;
  logic [15:0] s1_dist_q;
  logic [15:0] s1_amp_q;
  logic [8:0]  s1_col_q;
  logic [7:0]  s1_row_q;
  logic        s1_has_amp_q;
  logic        s2_ready;
  logic        s1_ready;

  assign s1_ready    = !s1_v_q || s2_ready;
  assign pix_i.ready = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_ready) begin
      s1_v_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && pix_i.valid) begin
      s1_dist_q    <= pix_i.distance_code;
      s1_amp_q     <= pix_i.amplitude;
      s1_col_q     <= pix_i.column;
      s1_row_q     <= pix_i.row;
      s1_has_amp_q <= pix_i.has_amplitude;
    end
  end

  // pixel logic
  logic [15:0]       dist_clean;
  rgb_t              rgb_raw;
  rgb_t              rgb_d;
  logic signed [11:0] x_s, y_s, c_s, wm_s, hm_s;
  logic              in_cut;
  logic              valid_d;

  always_comb begin
    if (s1_dist_q == CODE_LOW_AMP || s1_dist_q == CODE_INTERF ||
        s1_dist_q == CODE_EDGE) begin
      dist_clean = 16'd0;
    end else begin
      dist_clean = s1_dist_q;
    end
  end

  tpcm_colorize u_colorize (
    .dist_i (dist_clean),
    .rgb_o  (rgb_raw)
  );

  assign x_s  = signed'({3'b000, s1_col_q});
  assign y_s  = signed'({4'b0000, s1_row_q});
  assign c_s  = signed'({4'b0000, cut_q});
  assign wm_s = WM_BASE - c_s;
  assign hm_s = HM_BASE - c_s;

  assign in_cut = (y_s > c_s - x_s) && (y_s > x_s - wm_s) && (y_s < x_s + hm_s) &&
                  (x_s + y_s < HM_BASE + wm_s);

  assign rgb_d   = in_cut ? rgb_raw : '0;
  assign valid_d = in_cut && (dist_clean != 16'd0) && (dist_clean < range_limit(mode_q));

  // result register
  logic              s2_v_q;
  rgb_t              s2_rgb_q;
  logic              s2_pv_q;
  logic [15:0]       s2_depth_q;
  logic [8:0]        s2_lat_q;
  logic [7:0]        s2_ver_q;
  logic [15:0]       s2_int_q;

  assign s2_ready = !s2_v_q || pt_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_ready) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_v_q) begin
      s2_rgb_q <= rgb_d;
      s2_pv_q  <= valid_d;
      if (valid_d) begin
        s2_depth_q <= dist_clean;
        s2_lat_q   <= LAT_OFS - s1_col_q;
        s2_ver_q   <= VER_OFS - s1_row_q;
        s2_int_q   <= s1_has_amp_q ? s1_amp_q : dist_clean;
      end else begin
        s2_depth_q <= 16'd0;
        s2_lat_q   <= 9'd0;
        s2_ver_q   <= 8'd0;
        s2_int_q   <= 16'd0;
      end
    end
  end

  assign pt_o.valid          = s2_v_q;
  assign pt_o.red            = s2_rgb_q.red;
  assign pt_o.green          = s2_rgb_q.green;
  assign pt_o.blue           = s2_rgb_q.blue;
  assign pt_o.point_valid    = s2_pv_q;
  assign pt_o.point_depth_mm = s2_depth_q;
  assign pt_o.point_lateral  = signed'(s2_lat_q);
  assign pt_o.point_vertical = signed'(s2_ver_q);
  assign pt_o.intensity      = s2_int_q;

endmodule

`default_nettype wire
